/* src/fsl_pkg.sv */
`timescale 1ns / 1ps
package fsl_pkg;

  typedef logic signed [31:0] q_t;

  localparam int Q_ONE             = 65536;
  localparam int ATAN_C1           = 65333;
  localparam int ATAN_C2           = 20795;
  localparam int TWO_PI_Q          = 411775;
  localparam int EXP_CAP           = 8221 * 65536;
  localparam int DEF_CELL_DISTANCE = 30;
  localparam int WRAP_RW           = $clog2(TWO_PI_Q + 1);

  localparam int CFG_IDX_W = 4;
  localparam logic [CFG_IDX_W-1:0] REG_FWI_WEIGHT    = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ASPECT_WEIGHT = 4'd1;
  localparam logic [CFG_IDX_W-1:0] REG_WIND_WEIGHT   = 4'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ELEV_WEIGHT   = 4'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SLOPE_WEIGHT  = 4'd4;
  localparam logic [CFG_IDX_W-1:0] REG_MEAN_ELEV     = 4'd5;
  localparam logic [CFG_IDX_W-1:0] REG_ELEV_SPREAD   = 4'd6;
  localparam logic [CFG_IDX_W-1:0] REG_PROB_CEILING  = 4'd7;

  localparam q_t Q_MAX = 32'sh7FFF_FFFF;
  localparam q_t Q_MIN = 32'sh8000_0000;

  function automatic q_t sat_add(input q_t a, input q_t b);
    logic [32:0] t;
    t = {a[31], a} + {b[31], b};
    if (t[32] != t[31]) return t[32] ? Q_MIN : Q_MAX;
    return q_t'(t[31:0]);
  endfunction

  function automatic q_t sat_sub(input q_t a, input q_t b);
    logic [32:0] t;
    t = {a[31], a} - {b[31], b};
    if (t[32] != t[31]) return t[32] ? Q_MIN : Q_MAX;
    return q_t'(t[31:0]);
  endfunction

  // Q16.16 product, floor rounding, saturated
  function automatic q_t qmul(input q_t a, input q_t b);
    logic [63:0] p;
    logic [47:0] s;
    p = {{32{a[31]}}, a} * {{32{b[31]}}, b};
    s = p[63:16];
    if (!s[47] && (s[46:31] != '0)) return Q_MAX;
    if (s[47] && (s[46:31] != '1)) return Q_MIN;
    return q_t'(s[31:0]);
  endfunction

endpackage

/* src/fsl_delay.sv */
`timescale 1ns / 1ps
module fsl_delay #(
  parameter int W = 32,
  parameter int N = 1
) (
  input  logic         clk,
  input  logic         en,
  input  logic [W-1:0] d,
  output logic [W-1:0] q
);

  logic [W-1:0] taps [N];

  always_ff @(posedge clk) begin
    if (en) begin
      taps[0] <= d;
      for (int i = 1; i < N; i++) taps[i] <= taps[i-1];
    end
  end

  assign q = taps[N-1];

endmodule

/* src/fsl_cdiv.sv */
`timescale 1ns / 1ps
// signed divide by a constant, truncating toward zero; two stages
module fsl_cdiv #(
  parameter int unsigned DIV = 2,
  parameter int RW = $clog2(DIV + 1)
) (
  input  logic                clk,
  input  logic                en,
  input  logic signed [31:0]  a,
  output logic signed [31:0]  q,
  output logic [RW-1:0]       rem,
  output logic                neg
);

  localparam logic [31:0] RECIP = 32'(64'h0000_0000_FFFF_FFFF / 64'(DIV));

  logic [31:0] mag;
  logic [63:0] prod;
  logic [31:0] m1;
  logic [31:0] q0;
  logic        neg1;
  logic [63:0] back;
  logic [31:0] r;
  logic        ge;
  logic [31:0] qc;
  logic [31:0] rc;

  assign mag  = a[31] ? 32'(-a) : 32'(a);
  assign prod = 64'(mag) * 64'(RECIP);

  // estimate is exact or one short
  assign back = 64'(q0) * 64'(DIV);
  assign r    = m1 - back[31:0];
  assign ge   = (r >= 32'(DIV));
  assign qc   = q0 + 32'(ge);
  assign rc   = ge ? (r - 32'(DIV)) : r;

  always_ff @(posedge clk) begin
    if (en) begin
      m1   <= mag;
      q0   <= prod[63:32];
      neg1 <= a[31];
      q    <= neg1 ? -signed'(qc) : signed'(qc);
      rem  <= rc[RW-1:0];
      neg  <= neg1;
    end
  end

endmodule

/* src/fsl_udiv.sv */
`timescale 1ns / 1ps
// pipelined restoring divider, one quotient bit per stage;
// needs dividend < divisor * 2**QW
module fsl_udiv #(
  parameter int NW = 48,
  parameter int DW = 31,
  parameter int QW = 48
) (
  input  logic          clk,
  input  logic          en,
  input  logic [NW-1:0] dividend,
  input  logic [DW-1:0] divisor,
  output logic [QW-1:0] quotient
);

  logic [DW-1:0] rem_r [QW];
  logic [QW-1:0] low_r [QW];
  logic [QW-1:0] quo_r [QW];
  logic [DW-1:0] dvs_r [QW];

  logic [DW-1:0] rem_n [QW];
  logic [QW-1:0] low_n [QW];
  logic [QW-1:0] quo_n [QW];
  logic [DW-1:0] dvs_n [QW];

  logic [NW-1:0] hi;
  logic [DW-1:0] rem0;

  assign hi   = dividend >> QW;
  assign rem0 = hi[DW-1:0];

  always_comb begin
    logic [DW-1:0] p_rem;
    logic [QW-1:0] p_low;
    logic [QW-1:0] p_quo;
    logic [DW-1:0] p_dvs;
    logic [DW:0]   t;
    logic          ge;
    for (int i = 0; i < QW; i++) begin
      if (i == 0) begin
        p_rem = rem0;
        p_low = dividend[QW-1:0];
        p_quo = '0;
        p_dvs = divisor;
      end else begin
        p_rem = rem_r[i-1];
        p_low = low_r[i-1];
        p_quo = quo_r[i-1];
        p_dvs = dvs_r[i-1];
      end
      t  = {p_rem, p_low[QW-1]};
      ge = (t >= {1'b0, p_dvs});
      rem_n[i] = ge ? DW'(t - {1'b0, p_dvs}) : DW'(t);
      quo_n[i] = QW'({p_quo, ge});
      low_n[i] = p_low << 1;
      dvs_n[i] = p_dvs;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < QW; i++) begin
        rem_r[i] <= rem_n[i];
        low_r[i] <= low_n[i];
        quo_r[i] <= quo_n[i];
        dvs_r[i] <= dvs_n[i];
      end
    end
  end

  assign quotient = quo_r[QW-1];

endmodule

/* src/fire_spread_logistic_prob_top.sv */
`timescale 1ns / 1ps
// Fire spread probability pipeline. One burning-cell / neighbour pair may be
// transferred on every clock; its spread probability comes out in order, one
// result per pair. Latency is set by the two long dividers: the elevation
// standardisation (48 stages, one quotient bit each) and the final ceiling /
// (1 + exp) divide (17 stages); the slope and wind polynomials run alongside
// the first, the quartic exp between them, in single-multiplier stages. A held
// result freezes the whole pipeline, so pair_stall rises only while prob_valid
// is stalled. Configuration writes are always taken (cfg_ready is tied high)
// and must only be made while no pair is in flight. All values are signed Q16.16
// with saturation; spread_prob is unsigned Q1.16 in 0 .. min(prob_ceiling, 1.0).
module fire_spread_logistic_prob_top
  import fsl_pkg::*;
#(
  parameter int CELL_DISTANCE = DEF_CELL_DISTANCE
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 pair_valid,
  output logic                 pair_stall,
  input  logic signed [31:0]   src_elevation,
  input  logic signed [31:0]   src_wind_dir,
  input  logic signed [31:0]   nbr_fwi,
  input  logic signed [31:0]   nbr_aspect,
  input  logic signed [31:0]   nbr_elevation,
  input  logic signed [31:0]   base_linpred,
  input  logic signed [31:0]   nbr_angle,
  output logic                 prob_valid,
  input  logic                 prob_stall,
  output logic [16:0]          spread_prob,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]          cfg_data
);

  localparam int LAT = 80;

  // configuration
  q_t          fwi_weight, aspect_weight, wind_weight, elev_weight, slope_weight;
  q_t          mean_elev;
  logic [30:0] elev_spread;
  logic [16:0] prob_ceiling;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      fwi_weight    <= '0;
      aspect_weight <= '0;
      wind_weight   <= '0;
      elev_weight   <= '0;
      slope_weight  <= '0;
      mean_elev     <= '0;
      elev_spread   <= 31'(Q_ONE);
      prob_ceiling  <= 17'(Q_ONE);
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_FWI_WEIGHT:    fwi_weight    <= q_t'(cfg_data);
        REG_ASPECT_WEIGHT: aspect_weight <= q_t'(cfg_data);
        REG_WIND_WEIGHT:   wind_weight   <= q_t'(cfg_data);
        REG_ELEV_WEIGHT:   elev_weight   <= q_t'(cfg_data);
        REG_SLOPE_WEIGHT:  slope_weight  <= q_t'(cfg_data);
        REG_MEAN_ELEV:     mean_elev     <= q_t'(cfg_data);
        REG_ELEV_SPREAD:   elev_spread   <= cfg_data[30:0];
        REG_PROB_CEILING:  prob_ceiling  <= cfg_data[16:0];
        default: ;
      endcase
    end
  end

  // pipeline advance: everything moves unless the result is held
  logic           en;
  logic [LAT-1:0] vld;

  assign en         = !(vld[LAT-1] && prob_stall);
  assign pair_stall = !en;
  assign prob_valid = vld[LAT-1];

  always_ff @(posedge clk) begin
    if (rst) vld <= '0;
    else if (en) vld <= {vld[LAT-2:0], pair_valid};
  end

  // stage registers (stage number in comments)
  q_t s_d, w_dd, e0, pf, pa, base1;           // 1
  q_t l1, pa2;                                 // 2
  q_t l2;                                      // 3
  q_t xx, n;                                   // 4
  q_t tt, n2;                                  // 5
  q_t u, n4, h1;                               // 6
  q_t at, h2;                                  // 7
  q_t a2, at1, h3;                             // 8
  q_t a3, a2_1;                                // 9
  q_t a5, w1;                                  // 10 / 9
  q_t a36_1, wind;                             // 12 / 10
  q_t pw;                                      // 11
  q_t l3;                                      // 12
  q_t s1;                                      // 13
  q_t slope;                                   // 14
  q_t ps;                                      // 15
  q_t elev;                                    // 50
  q_t pe;                                      // 51
  q_t l4;                                      // 52
  q_t l5;                                      // 53
  q_t xe;                                      // 54
  q_t x2, xe1;                                 // 55
  q_t x3, xe2, hx;                             // 56
  q_t x4;                                      // 57
  q_t x36_1;                                   // 59
  q_t es1;                                     // 60
  q_t es2;                                     // 61
  q_t es3;                                     // 62
  q_t ec;                                      // 63

  // unit outputs
  q_t                 x, x_d3, a36, a5d, at_d, n4d, l2d, l3d, ps_d;
  q_t                 x36, x424, hx_d, xe_d;
  logic [WRAP_RW-1:0] w_rem;
  logic               w_neg;
  logic [47:0]        eq;
  logic               e_neg_d;
  logic [16:0]        quo;

  // wind angle wrapped to +-pi from the remainder of |d| / 2pi
  logic [32:0]        rem2;
  q_t                 rr, nm, n_next;
  assign rr     = q_t'(32'(w_rem));
  assign rem2   = {33'(w_rem)} << 1;
  assign nm     = (rem2 > 33'(TWO_PI_Q)) ? (rr - q_t'(TWO_PI_Q)) : rr;
  assign n_next = w_neg ? -nm : nm;

  // elevation standardisation operands
  logic [31:0] e0_mag;
  logic [30:0] spread_eff;
  assign e0_mag     = e0[31] ? 32'(-e0) : 32'(e0);
  assign spread_eff = (elev_spread == '0) ? 31'd1 : elev_spread;

  // saturate signed quotient magnitude
  q_t elev_next;
  always_comb begin
    if (e_neg_d) begin
      if ((eq[47:32] != '0) || (eq[31] && (eq[30:0] != '0))) elev_next = Q_MIN;
      else elev_next = -q_t'(eq[31:0]);
    end else begin
      if (eq[47:31] != '0) elev_next = Q_MAX;
      else elev_next = q_t'(eq[31:0]);
    end
  end

  // exp clamp: capped at the quartic's value at 20, never negative
  q_t e_sum, ec_next;
  assign e_sum = sat_add(q_t'(Q_ONE), es3);
  always_comb begin
    priority if (e_sum > q_t'(EXP_CAP)) ec_next = q_t'(EXP_CAP);
    else if (e_sum < 0) ec_next = '0;
    else ec_next = e_sum;
  end

  logic [16:0] ceil_c;
  logic [29:0] denom;
  assign ceil_c = (prob_ceiling > 17'(Q_ONE)) ? 17'(Q_ONE) : prob_ceiling;
  assign denom  = ec[29:0] + 30'(Q_ONE);

  always_ff @(posedge clk) begin
    if (en) begin
      // front end
      s_d   <= sat_sub(nbr_elevation, src_elevation);
      w_dd  <= sat_sub(nbr_angle, src_wind_dir);
      e0    <= sat_sub(nbr_elevation, mean_elev);
      pf    <= qmul(fwi_weight, nbr_fwi);
      pa    <= qmul(aspect_weight, nbr_aspect);
      base1 <= base_linpred;
      l1    <= sat_add(base1, pf);
      pa2   <= pa;
      l2    <= sat_add(l1, pa2);
      // slope: atan then sine
      xx    <= qmul(x, x);
      tt    <= qmul(q_t'(ATAN_C2), xx);
      u     <= sat_sub(q_t'(ATAN_C1), tt);
      at    <= qmul(x_d3, u);
      a2    <= qmul(at, at);
      at1   <= at;
      a3    <= qmul(at1, a2);
      a2_1  <= a2;
      a5    <= qmul(a3, a2_1);
      a36_1 <= a36;
      s1    <= sat_sub(a36_1, a5d);
      slope <= sat_sub(at_d, s1);
      ps    <= qmul(slope, slope_weight);
      // wind: cosine of wrapped angle
      n     <= n_next;
      n2    <= qmul(n, n);
      n4    <= qmul(n2, n2);
      h1    <= n2 >>> 1;              // n2 is never negative
      h2    <= h1;
      h3    <= h2;
      w1    <= sat_sub(h3, n4d);
      wind  <= sat_sub(q_t'(Q_ONE), w1);
      pw    <= qmul(wind, wind_weight);
      l3    <= sat_add(l2d, pw);
      // elevation and the last sums
      elev  <= elev_next;
      pe    <= qmul(elev, elev_weight);
      l4    <= sat_add(l3d, pe);
      l5    <= sat_add(l4, ps_d);
      // quartic exp of -linpred
      xe    <= sat_sub('0, l5);
      x2    <= qmul(xe, xe);
      xe1   <= xe;
      x3    <= qmul(x2, xe1);
      xe2   <= xe1;
      hx    <= x2 >>> 1;              // x2 is never negative
      x4    <= qmul(x3, xe2);
      x36_1 <= x36;
      es1   <= sat_add(x36_1, x424);
      es2   <= sat_add(hx_d, es1);
      es3   <= sat_add(xe_d, es2);
      ec    <= ec_next;
    end
  end

  // slope path units
  fsl_cdiv #(.DIV(CELL_DISTANCE)) u_div_dist (
    .clk(clk), .en(en), .a(s_d), .q(x), .rem(), .neg()
  );
  fsl_delay #(.W(32), .N(3)) u_dly_x (.clk(clk), .en(en), .d(x), .q(x_d3));
  fsl_cdiv #(.DIV(6)) u_div_a3 (
    .clk(clk), .en(en), .a(a3), .q(a36), .rem(), .neg()
  );
  fsl_cdiv #(.DIV(120)) u_div_a5 (
    .clk(clk), .en(en), .a(a5), .q(a5d), .rem(), .neg()
  );
  fsl_delay #(.W(32), .N(6)) u_dly_at (.clk(clk), .en(en), .d(at), .q(at_d));
  fsl_delay #(.W(32), .N(37)) u_dly_ps (.clk(clk), .en(en), .d(ps), .q(ps_d));

  // wind path units
  fsl_cdiv #(.DIV(TWO_PI_Q), .RW(WRAP_RW)) u_div_wrap (
    .clk(clk), .en(en), .a(w_dd), .q(), .rem(w_rem), .neg(w_neg)
  );
  fsl_cdiv #(.DIV(24)) u_div_n4 (
    .clk(clk), .en(en), .a(n4), .q(n4d), .rem(), .neg()
  );

  // linear predictor alignment
  fsl_delay #(.W(32), .N(8)) u_dly_l2 (.clk(clk), .en(en), .d(l2), .q(l2d));
  fsl_delay #(.W(32), .N(39)) u_dly_l3 (.clk(clk), .en(en), .d(l3), .q(l3d));

  // elevation standardisation
  fsl_udiv #(.NW(48), .DW(31), .QW(48)) u_div_elev (
    .clk(clk), .en(en), .dividend({e0_mag, 16'd0}), .divisor(spread_eff),
    .quotient(eq)
  );
  fsl_delay #(.W(1), .N(48)) u_dly_eneg (
    .clk(clk), .en(en), .d(e0[31]), .q(e_neg_d)
  );

  // exp path units
  fsl_cdiv #(.DIV(6)) u_div_x3 (
    .clk(clk), .en(en), .a(x3), .q(x36), .rem(), .neg()
  );
  fsl_cdiv #(.DIV(24)) u_div_x4 (
    .clk(clk), .en(en), .a(x4), .q(x424), .rem(), .neg()
  );
  fsl_delay #(.W(32), .N(4)) u_dly_hx (.clk(clk), .en(en), .d(hx), .q(hx_d));
  fsl_delay #(.W(32), .N(7)) u_dly_xe (.clk(clk), .en(en), .d(xe), .q(xe_d));

  // ceiling / (1 + exp)
  fsl_udiv #(.NW(33), .DW(30), .QW(17)) u_div_prob (
    .clk(clk), .en(en), .dividend({ceil_c, 16'd0}), .divisor(denom),
    .quotient(quo)
  );

  assign spread_prob = quo;

endmodule

/* src/fsl_checker.sv */
`timescale 1ns / 1ps
module fsl_checker
  import fsl_pkg::*;
(
  input logic        clk,
  input logic        rst,
  input logic        pair_stall,
  input logic        prob_valid,
  input logic        prob_stall,
  input logic [16:0] spread_prob
);

  a_hold: assert property (@(posedge clk) disable iff (rst)
    prob_valid && prob_stall |=> prob_valid && $stable(spread_prob))
    else $error("result changed while stalled");

  a_range: assert property (@(posedge clk) disable iff (rst)
    prob_valid |-> spread_prob <= 17'(Q_ONE))
    else $error("probability above one");

  a_stall_cause: assert property (@(posedge clk)
    pair_stall |-> prob_valid && prob_stall)
    else $error("input stalled without a held result");

  a_reset_empty: assert property (@(posedge clk) disable iff (rst)
    $past(rst) |-> !prob_valid)
    else $error("result valid straight after reset");

endmodule

bind fire_spread_logistic_prob_top fsl_checker u_fsl_checker (
  .clk(clk), .rst(rst), .pair_stall(pair_stall), .prob_valid(prob_valid),
  .prob_stall(prob_stall), .spread_prob(spread_prob)
);

/* sim/tb_fire_spread_logistic_prob_top.sv */
`timescale 1ns / 1ps
module tb_fire_spread_logistic_prob_top;
  import fsl_pkg::*;

  localparam int DIST      = DEF_CELL_DISTANCE;
  localparam int LATENCY   = 80;
  localparam int WDOG_MAX  = 20000;
  localparam longint L_MAX = 64'sd2147483647;
  localparam longint L_MIN = -64'sd2147483648;

  typedef struct packed {
    logic [31:0] src_elev;
    logic [31:0] wind_dir;
    logic [31:0] fwi;
    logic [31:0] aspect;
    logic [31:0] nbr_elev;
    logic [31:0] lin;
    logic [31:0] ang;
  } pair_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic pair_valid = 1'b0;
  logic pair_stall;
  logic signed [31:0] src_elevation = '0, src_wind_dir = '0, nbr_fwi = '0;
  logic signed [31:0] nbr_aspect = '0, nbr_elevation = '0, base_linpred = '0;
  logic signed [31:0] nbr_angle = '0;
  logic prob_valid;
  logic prob_stall = 1'b0;
  logic [16:0] spread_prob;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [31:0] cfg_data = '0;

  fire_spread_logistic_prob_top dut (.*);

  initial begin
    forever #5 clk = ~clk;
  end

  // testbench copy of the register file
  longint w_fwi, w_aspect, w_wind, w_elev, w_slope, e_mean, e_spread, p_ceil;

  pair_t       pair_q[$];   // pairs waiting to be driven
  logic [16:0] prob_q[$];   // predicted probabilities, oldest first
  int          n_err = 0;
  int          idle_cycles = 0;
  bit          hold_send = 1'b0;
  int          send_gap = 0;
  int          recv_gap = 0;

  function automatic longint sat32(longint v);
    if (v > L_MAX) return L_MAX;
    if (v < L_MIN) return L_MIN;
    return v;
  endfunction

  // Q16.16 product, rounded toward minus infinity
  function automatic longint fx_mul(longint a, longint b);
    return sat32((a * b) >>> 16);
  endfunction

  function automatic longint wrap_pi(longint d);
    longint q, r;
    q = d / TWO_PI_Q;
    r = d - q * TWO_PI_Q;
    if (r < 0) begin
      q -= 1;
      r += TWO_PI_Q;
    end
    if (2 * r > TWO_PI_Q) q += 1;
    return d - q * TWO_PI_Q;
  endfunction

  function automatic logic [16:0] spread_prob_of(pair_t p);
    longint se, wd, fw, asp, ne, lin, ang;
    longint x, at, a2, a3, a5, slope, n, n2, n4, wind, elev, div;
    longint e, e2, e3, e4, s, ceil_v, prob;
    se  = longint'($signed(p.src_elev));
    wd  = longint'($signed(p.wind_dir));
    fw  = longint'($signed(p.fwi));
    asp = longint'($signed(p.aspect));
    ne  = longint'($signed(p.nbr_elev));
    lin = longint'($signed(p.lin));
    ang = longint'($signed(p.ang));
    x = sat32(ne - se) / DIST;
    at = fx_mul(x, sat32(ATAN_C1 - fx_mul(ATAN_C2, fx_mul(x, x))));
    a2 = fx_mul(at, at);
    a3 = fx_mul(at, a2);
    a5 = fx_mul(a3, a2);
    slope = sat32(at - sat32(a3 / 6 - a5 / 120));
    n = wrap_pi(sat32(ang - wd));
    n2 = fx_mul(n, n);
    n4 = fx_mul(n2, n2);
    wind = sat32(Q_ONE - sat32(n2 / 2 - n4 / 24));
    div = (e_spread == 0) ? 1 : e_spread;
    elev = sat32((sat32(ne - e_mean) * 65536) / div);
    lin = sat32(lin + fx_mul(w_fwi, fw));
    lin = sat32(lin + fx_mul(w_aspect, asp));
    lin = sat32(lin + fx_mul(wind, w_wind));
    lin = sat32(lin + fx_mul(elev, w_elev));
    lin = sat32(lin + fx_mul(slope, w_slope));
    e = sat32(-lin);
    e2 = fx_mul(e, e);
    e3 = fx_mul(e2, e);
    e4 = fx_mul(e3, e);
    s = sat32(e3 / 6 + e4 / 24);
    s = sat32(e2 / 2 + s);
    s = sat32(e + s);
    s = sat32(Q_ONE + s);
    if (s > EXP_CAP) s = EXP_CAP;
    if (s < 0) s = 0;
    ceil_v = (p_ceil > Q_ONE) ? Q_ONE : p_ceil;
    prob = (ceil_v * 65536) / (Q_ONE + s);
    return prob[16:0];
  endfunction

  function automatic int rand_gap();
    if ($urandom_range(0, 19) == 0) return $urandom_range(10, 40);
    if ($urandom_range(0, 2) == 0) return $urandom_range(1, 3);
    return 0;
  endfunction

  // Driver: the front of the queue is on the pins until it is transferred
  always @(posedge clk) begin
    if (!rst) begin
      if (pair_valid && !pair_stall) pair_q.pop_front();
      if (pair_valid && pair_stall) begin
        // payload held
      end else if (send_gap > 0) begin
        send_gap <= send_gap - 1;
        pair_valid <= 1'b0;
      end else if (!hold_send && pair_q.size() > 0) begin
        automatic pair_t p = pair_q[0];
        pair_valid    <= 1'b1;
        src_elevation <= p.src_elev;
        src_wind_dir  <= p.wind_dir;
        nbr_fwi       <= p.fwi;
        nbr_aspect    <= p.aspect;
        nbr_elevation <= p.nbr_elev;
        base_linpred  <= p.lin;
        nbr_angle     <= p.ang;
        send_gap      <= rand_gap();
      end else begin
        pair_valid <= 1'b0;
      end
    end
  end

  // Prediction on every accepted pair transfer
  always @(posedge clk) begin
    if (!rst && pair_valid && !pair_stall)
      prob_q.push_back(spread_prob_of({src_elevation, src_wind_dir, nbr_fwi,
                                       nbr_aspect, nbr_elevation, base_linpred,
                                       nbr_angle}));
  end

  // Monitor and random receiver stall
  always @(posedge clk) begin
    if (!rst) begin
      if (prob_valid && !prob_stall) begin
        if (prob_q.size() == 0) begin
          n_err++;
          if (n_err <= 10) $display("unexpected result %0d", spread_prob);
        end else begin
          automatic logic [16:0] want = prob_q.pop_front();
          if (want !== spread_prob) begin
            n_err++;
            if (n_err <= 10)
              $display("spread_prob mismatch: expected %0d actual %0d",
                       want, spread_prob);
          end
        end
      end
      if (recv_gap > 0) begin
        recv_gap   <= recv_gap - 1;
        prob_stall <= 1'b1;
      end else begin
        recv_gap   <= rand_gap();
        prob_stall <= 1'b0;
      end
    end
  end

  // Watchdog: cycles without any transfer
  always @(posedge clk) begin
    if ((pair_valid && !pair_stall) || (prob_valid && !prob_stall) ||
        (pair_q.size() == 0 && prob_q.size() == 0))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WDOG_MAX) begin
      $display("tb_fire_spread_logistic_prob_top: done, errors");
      $finish;
    end
  end

  // one write, then cfg_valid is dropped before the next write
  task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [31:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    @(posedge clk);
    case (idx)
      REG_FWI_WEIGHT:    w_fwi    = longint'($signed(val));
      REG_ASPECT_WEIGHT: w_aspect = longint'($signed(val));
      REG_WIND_WEIGHT:   w_wind   = longint'($signed(val));
      REG_ELEV_WEIGHT:   w_elev   = longint'($signed(val));
      REG_SLOPE_WEIGHT:  w_slope  = longint'($signed(val));
      REG_MEAN_ELEV:     e_mean   = longint'($signed(val));
      REG_ELEV_SPREAD:   e_spread = longint'(val[30:0]);
      REG_PROB_CEILING:  p_ceil   = longint'(val[16:0]);
      default: ;
    endcase
  endtask

  // Wait until all pairs are out and every result has come
  task automatic drain();
    while (pair_q.size() != 0 || pair_valid || prob_q.size() != 0) @(posedge clk);
    repeat (LATENCY) @(posedge clk);
  endtask

  function automatic logic [31:0] rnd_q();
    case ($urandom_range(0, 5))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return $urandom_range(0, 65536 * 8) - 65536 * 4;
      3: return $urandom_range(0, 65536 * 64) - 65536 * 32;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [31:0] small_w();
    return ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 131072) - 65536;
  endfunction

  function automatic pair_t rnd_pair();
    pair_t p;
    p.src_elev = rnd_q();
    p.wind_dir = rnd_q();
    p.fwi      = rnd_q();
    p.aspect   = rnd_q();
    p.nbr_elev = ($urandom_range(0, 1)) ? p.src_elev + $urandom_range(0, 65536 * 60)
                                          - 65536 * 30 : rnd_q();
    p.lin      = rnd_q();
    p.ang      = rnd_q();
    return p;
  endfunction

  task automatic rand_config();
    cfg_write(REG_FWI_WEIGHT, small_w());
    cfg_write(REG_ASPECT_WEIGHT, small_w());
    cfg_write(REG_WIND_WEIGHT, small_w());
    cfg_write(REG_ELEV_WEIGHT, small_w());
    cfg_write(REG_SLOPE_WEIGHT, small_w());
    cfg_write(REG_MEAN_ELEV, rnd_q());
    cfg_write(REG_ELEV_SPREAD,
              ($urandom_range(0, 4) == 0) ? $urandom : $urandom_range(0, 65536 * 4));
    cfg_write(REG_PROB_CEILING,
              ($urandom_range(0, 4) == 0) ? $urandom : $urandom_range(0, 65536));
  endtask

  initial begin
    pair_t p;
    w_fwi = 0; w_aspect = 0; w_wind = 0; w_elev = 0; w_slope = 0;
    e_mean = 0; e_spread = 65536; p_ceil = 65536;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: reset registers, field extremes
    for (int i = 0; i < 8; i++) begin
      p = '0;
      case (i)
        0: ;
        1: p = '1;
        2: p = {7{32'h7FFF_FFFF}};
        3: p = {7{32'h8000_0000}};
        4: begin p.lin = 32'h8000_0000; end
        5: begin p.lin = 32'h7FFF_FFFF; end
        6: begin p.ang = 32'h7FFF_FFFF; p.wind_dir = 32'h8000_0000; end
        default: begin p.nbr_elev = 32'h7FFF_FFFF; p.src_elev = 32'h8000_0000; end
      endcase
      pair_q.push_back(p);
    end
    drain();

    // extreme weights, zero spread, ceiling above one, unused index
    cfg_write(REG_FWI_WEIGHT, 32'h7FFF_FFFF);
    cfg_write(REG_ASPECT_WEIGHT, 32'h8000_0000);
    cfg_write(REG_WIND_WEIGHT, 32'h7FFF_FFFF);
    cfg_write(REG_ELEV_WEIGHT, 32'h8000_0000);
    cfg_write(REG_SLOPE_WEIGHT, 32'h7FFF_FFFF);
    cfg_write(REG_MEAN_ELEV, 32'h8000_0000);
    cfg_write(REG_ELEV_SPREAD, 32'h0);
    cfg_write(REG_PROB_CEILING, 32'h1FFFF);
    cfg_write(CFG_IDX_W'(8), 32'h1234_5678);
    cfg_write(CFG_IDX_W'(15), 32'hFFFF_FFFF);
    for (int i = 0; i < 10; i++) pair_q.push_back(rnd_pair());
    drain();
    cfg_write(REG_PROB_CEILING, 32'h0);
    cfg_write(REG_ELEV_SPREAD, 32'h7FFF_FFFF);
    for (int i = 0; i < 5; i++) pair_q.push_back(rnd_pair());
    drain();

    // random phases, each with new register settings
    for (int ph = 0; ph < 6; ph++) begin
      rand_config();
      // sender holds off until the pipe has emptied once per phase
      for (int i = 0; i < 100; i++) begin
        if (i == 50) begin
          hold_send = 1'b1;
          while (pair_q.size() != 0 || pair_valid || prob_q.size() != 0) @(posedge clk);
          hold_send = 1'b0;
        end
        pair_q.push_back(rnd_pair());
        if (i == 49) while (pair_q.size() != 0) @(posedge clk);
      end
      drain();
    end

    if (n_err == 0) $display("tb_fire_spread_logistic_prob_top: done, clean");
    else $display("tb_fire_spread_logistic_prob_top: done, errors");
    $finish;
  end

endmodule
